### hdl/mlp_pkg.sv
`default_nettype none
package mlp_pkg;

    // transaction kinds on the input channel
    localparam logic ACTION_WEIGHT  = 1'b0;
    localparam logic ACTION_FEATURE = 1'b1;

    localparam int ACC_W  = 32;
    localparam int PROD_W = 34;
    localparam int FEAT_W = 17;
    localparam int ACT_W  = 16;
    localparam logic [FEAT_W-1:0] FEAT_MAX = 17'd65536;
    localparam int MAX_RESULTS = 4;

    // piecewise sigmoid, Q16.16 in, Q0.16 out
    localparam int SIG_NUM_W = 46;
    localparam int SIG_Q_W   = 16;
    localparam int SIG_RCP_W = 17;
    localparam logic signed [ACC_W-1:0] SIG_SAT_HI   = 32'sd524288;
    localparam logic signed [ACC_W-1:0] SIG_SAT_LO   = -32'sd524288;
    localparam logic signed [ACC_W-1:0] SIG_KNEE_HI  = 32'sd393216;
    localparam logic signed [ACC_W-1:0] SIG_KNEE_MID = 32'sd212992;
    localparam logic [SIG_NUM_W-1:0] SIG_BASE_HI   = 46'd654049280;
    localparam logic [SIG_NUM_W-1:0] SIG_BASE_MID  = 46'd638976000;
    localparam logic [4:0]           SIG_SLOPE_MID = 5'd28;
    localparam logic [24:0]          SIG_SLOPE_LIN = 25'd22200001;
    localparam logic [6:0]           SIG_SQ_GAIN   = 7'd71;
    localparam logic [29:0] SIG_DIV_HI  = 30'd10000;
    localparam logic [29:0] SIG_DIV_LIN = 30'd157130000;
    localparam logic [29:0] SIG_DIV_NEG = 30'd655360000;
    // reciprocals floor(2^k / divisor), k = 30, 43 and 45
    localparam logic [SIG_RCP_W-1:0] SIG_RCP_HI  = 17'd107374;
    localparam logic [SIG_RCP_W-1:0] SIG_RCP_LIN = 17'd55979;
    localparam logic [SIG_RCP_W-1:0] SIG_RCP_NEG = 17'd53687;
    localparam logic [SIG_Q_W-1:0] SIG_OFF_LIN = 16'd32768;
    localparam logic [SIG_Q_W-1:0] SIG_ONE     = 16'd65535;
    localparam logic [SIG_Q_W-1:0] SIG_ZERO    = 16'd0;

    typedef struct packed {
        logic store_wr;
        logic feat_wr;
        logic run_init;
        logic hid_init;
        logic out_init;
        logic input_layer;
        logic issue_bias;
        logic issue_term;
        logic sig_start;
        logic act_wr;
        logic out_load;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic sig_done;
    } t_dp_sts;

endpackage
`default_nettype wire

### hdl/mlp_sigmoid.sv
`default_nettype none
module mlp_sigmoid (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [mlp_pkg::ACC_W-1:0]    i_acc,
    output logic                                     o_done,
    output logic [mlp_pkg::SIG_Q_W-1:0]              o_result
);
    localparam logic [2:0] SG_IDLE = 3'd0;
    localparam logic [2:0] SG_PREP = 3'd1;
    localparam logic [2:0] SG_MUL  = 3'd2;
    localparam logic [2:0] SG_RLO  = 3'd3;
    localparam logic [2:0] SG_RHI  = 3'd4;
    localparam logic [2:0] SG_QUO  = 3'd5;
    localparam logic [2:0] SG_REM  = 3'd6;
    localparam logic [2:0] SG_FIX  = 3'd7;

    localparam logic [1:0] CAT_HI  = 2'd0;
    localparam logic [1:0] CAT_MID = 2'd1;
    localparam logic [1:0] CAT_LIN = 2'd2;
    localparam logic [1:0] CAT_NEG = 2'd3;

    localparam int NW  = mlp_pkg::SIG_NUM_W;
    localparam int QW  = mlp_pkg::SIG_Q_W;
    localparam int RW  = mlp_pkg::SIG_RCP_W;
    localparam int PRW = 62;

    logic [2:0]                          r_state;
    logic signed [mlp_pkg::ACC_W-1:0]    r_x;
    logic [1:0]                          r_cat;
    logic [44:0]                         r_m;
    logic [NW-1:0]                       r_num;
    logic [29:0]                         r_div;
    logic [RW-1:0]                       r_rcp;
    logic [PRW-1:0]                      r_p;
    logic [QW-1:0]                       r_off;
    logic [QW-1:0]                       r_q;
    logic                                r_done;
    logic [QW-1:0]                       r_res;

    logic signed [mlp_pkg::ACC_W-1:0]    u_full;
    logic [19:0]                         op_a;
    logic [24:0]                         op_b;
    logic                                pos;
    logic [NW-1:0]                       num_sel;
    logic [29:0]                         div_sel;
    logic [RW-1:0]                       rcp_sel;
    logic [QW-1:0]                       off_sel;
    logic [39:0]                         mul_lo;
    logic [38:0]                         mul_hi;
    logic [QW-1:0]                       q_est;
    logic [NW-1:0]                       qd;
    logic                                ge;

    // operand selection for the single multiplier of the prep step
    assign pos    = !r_x[mlp_pkg::ACC_W-1];
    assign u_full = r_x + 32'sd524288;
    assign op_a   = pos ? r_x[19:0] : u_full[19:0];
    assign op_b   = pos ? mlp_pkg::SIG_SLOPE_LIN : {5'd0, u_full[19:0]};

    // quotient by reciprocal multiply, numerator split in two halves
    assign mul_lo = {17'd0, r_num[22:0]} * {23'd0, r_rcp};
    assign mul_hi = {17'd0, r_num[44:23]} * {22'd0, r_rcp};
    assign qd     = {30'd0, r_q} * {16'd0, r_div};
    assign ge     = (r_num >= {16'd0, r_div});

    always_comb begin
        num_sel = '0;
        div_sel = mlp_pkg::SIG_DIV_HI;
        rcp_sel = mlp_pkg::SIG_RCP_HI;
        off_sel = '0;
        case (r_cat)
            CAT_HI: begin
                num_sel = mlp_pkg::SIG_BASE_HI + NW'(r_x[19:0]);
            end
            CAT_MID: begin
                num_sel = mlp_pkg::SIG_BASE_MID
                        + NW'(r_x[19:0]) * NW'(mlp_pkg::SIG_SLOPE_MID);
            end
            CAT_LIN: begin
                num_sel = NW'(r_m);
                div_sel = mlp_pkg::SIG_DIV_LIN;
                rcp_sel = mlp_pkg::SIG_RCP_LIN;
                off_sel = mlp_pkg::SIG_OFF_LIN;
            end
            default: begin
                num_sel = NW'(r_m) * NW'(mlp_pkg::SIG_SQ_GAIN);
                div_sel = mlp_pkg::SIG_DIV_NEG;
                rcp_sel = mlp_pkg::SIG_RCP_NEG;
            end
        endcase
    end

    // estimate is the true quotient or one below it
    always_comb begin
        case (r_cat)
            CAT_HI:  q_est = r_p[45:30];
            CAT_MID: q_est = r_p[45:30];
            CAT_LIN: q_est = r_p[58:43];
            default: q_est = r_p[60:45];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SG_IDLE: begin
                    if (i_start) begin
                        r_state <= SG_PREP;
                    end
                end
                SG_PREP: begin
                    if (r_x > mlp_pkg::SIG_SAT_HI || r_x < mlp_pkg::SIG_SAT_LO) begin
                        r_state <= SG_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= SG_MUL;
                    end
                end
                SG_MUL: begin
                    r_state <= SG_RLO;
                end
                SG_RLO: begin
                    r_state <= SG_RHI;
                end
                SG_RHI: begin
                    r_state <= SG_QUO;
                end
                SG_QUO: begin
                    r_state <= SG_REM;
                end
                SG_REM: begin
                    r_state <= SG_FIX;
                end
                SG_FIX: begin
                    r_state <= SG_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= SG_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SG_IDLE: begin
                r_x <= i_acc;
            end
            SG_PREP: begin
                r_m <= op_a * op_b;
                if (r_x > mlp_pkg::SIG_KNEE_HI) begin
                    r_cat <= CAT_HI;
                end else if (r_x > mlp_pkg::SIG_KNEE_MID) begin
                    r_cat <= CAT_MID;
                end else if (pos) begin
                    r_cat <= CAT_LIN;
                end else begin
                    r_cat <= CAT_NEG;
                end
                if (r_x > mlp_pkg::SIG_SAT_HI) begin
                    r_res <= mlp_pkg::SIG_ONE;
                end else begin
                    r_res <= mlp_pkg::SIG_ZERO;
                end
            end
            SG_MUL: begin
                r_num <= num_sel;
                r_div <= div_sel;
                r_rcp <= rcp_sel;
                r_off <= off_sel;
            end
            SG_RLO: begin
                r_p <= PRW'(mul_lo);
            end
            SG_RHI: begin
                r_p <= r_p + {mul_hi, 23'd0};
            end
            SG_QUO: begin
                r_q <= q_est;
            end
            SG_REM: begin
                r_num <= r_num - qd;
            end
            SG_FIX: begin
                // remainder left at or above the divisor means one more
                r_res <= r_q + QW'(ge) + r_off;
            end
            default: begin
                r_x <= i_acc;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

### hdl/mlp_datapath.sv
`default_nettype none
module mlp_datapath #(
    parameter int INPUT_COUNT  = 16,
    parameter int HIDDEN_COUNT = 16,
    parameter int LAYER_COUNT  = 2,
    parameter int OUTPUT_COUNT = 4,
    parameter int STORE_DEPTH  = 1024,
    localparam int AW  = $clog2(STORE_DEPTH),
    localparam int MXK = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT,
    localparam int KW  = $clog2((MXK > 2) ? MXK : 2),
    localparam int NOUT = (OUTPUT_COUNT < mlp_pkg::MAX_RESULTS) ? OUTPUT_COUNT
                                                                : mlp_pkg::MAX_RESULTS,
    localparam int MXN = (HIDDEN_COUNT > NOUT) ? HIDDEN_COUNT : NOUT,
    localparam int NW  = $clog2((MXN > 2) ? MXN : 2),
    localparam int FW  = $clog2(INPUT_COUNT)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mlp_pkg::t_dp_cmd                    i_cmd,
    input  wire logic [KW-1:0]                       i_term,
    input  wire logic [NW-1:0]                       i_neuron,
    input  wire logic [FW-1:0]                       i_feat_idx,
    input  wire logic                                i_bank,
    input  wire logic [9:0]                          i_weight_addr,
    input  wire logic signed [31:0]                  i_weight_value,
    input  wire logic [mlp_pkg::FEAT_W-1:0]          i_feature_value,
    output mlp_pkg::t_dp_sts                         o_sts,
    output logic [1:0]                               o_output_index,
    output logic [mlp_pkg::ACT_W-1:0]                o_output_value,
    output logic                                     o_last_output
);
    localparam int AMW = $clog2(2 * HIDDEN_COUNT);
    localparam int BIAS_BASE = INPUT_COUNT * HIDDEN_COUNT;
    localparam int HLW_BASE  = BIAS_BASE + LAYER_COUNT * HIDDEN_COUNT;
    localparam int OW_BASE   = HLW_BASE + (LAYER_COUNT - 1) * HIDDEN_COUNT * HIDDEN_COUNT;
    localparam int OB_BASE   = OW_BASE + OUTPUT_COUNT * HIDDEN_COUNT;
    localparam logic [AW-1:0] BIAS_PTR = AW'(BIAS_BASE % STORE_DEPTH);
    localparam logic [AW-1:0] HLW_PTR  = AW'(HLW_BASE % STORE_DEPTH);
    localparam logic [AW-1:0] OB_PTR   = AW'(OB_BASE % STORE_DEPTH);
    localparam logic [AW:0]   DEPTH_V  = (AW+1)'(STORE_DEPTH);
    localparam logic [AW:0]   ROW_STEP = (AW+1)'(INPUT_COUNT);
    localparam int PW = mlp_pkg::PROD_W;

    logic [31:0]                   r_store [0:STORE_DEPTH-1];
    logic [mlp_pkg::FEAT_W-1:0]    r_feat  [0:INPUT_COUNT-1];
    logic [mlp_pkg::ACT_W-1:0]     r_act   [0:2*HIDDEN_COUNT-1];

    logic [AW-1:0]                 r_wptr;
    logic [AW-1:0]                 r_bptr;
    logic [AW-1:0]                 r_row;
    logic [31:0]                   r_wq;
    logic [mlp_pkg::FEAT_W-1:0]    r_feat_q;
    logic [mlp_pkg::ACT_W-1:0]     r_act_q;
    logic                          r_s1_in;
    logic                          r_s1_bias;
    logic                          r_s1_term;
    logic                          r_s2_bias;
    logic                          r_s2_term;
    logic signed [PW-1:0]          r_prod;
    logic signed [31:0]            r_acc;
    logic [1:0]                    r_out_index;
    logic [mlp_pkg::ACT_W-1:0]     r_out_value;
    logic                          r_out_last;

    logic                          wr_ok;
    logic [mlp_pkg::FEAT_W-1:0]    feat_sat;
    logic [AW-1:0]                 rd_addr;
    logic [AMW-1:0]                act_rd_addr;
    logic [AMW-1:0]                act_wr_addr;
    logic [AW:0]                   row_sum;
    logic [mlp_pkg::FEAT_W-1:0]    mac_a;
    logic signed [49:0]            prod_full;
    logic signed [PW:0]            acc_sum;
    logic [mlp_pkg::SIG_Q_W-1:0]   sig_res;
    logic                          sig_done;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, p} + (AW+1)'(1);
        return (s == DEPTH_V) ? '0 : s[AW-1:0];
    endfunction

    assign wr_ok       = (int'(i_weight_addr) < STORE_DEPTH);
    assign feat_sat    = (i_feature_value > mlp_pkg::FEAT_MAX) ? mlp_pkg::FEAT_MAX
                                                               : i_feature_value;
    assign rd_addr     = i_cmd.issue_bias ? r_bptr : r_wptr;
    assign act_rd_addr = !i_bank ? AMW'(HIDDEN_COUNT) + AMW'(i_term) : AMW'(i_term);
    assign act_wr_addr = i_bank ? AMW'(HIDDEN_COUNT) + AMW'(i_neuron) : AMW'(i_neuron);
    assign row_sum     = {1'b0, r_row} + ROW_STEP;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr && wr_ok) begin
            r_store[AW'(i_weight_addr)] <= i_weight_value;
        end
        if (i_cmd.issue_bias || i_cmd.issue_term) begin
            r_wq <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.feat_wr) begin
            r_feat[i_feat_idx] <= feat_sat;
        end
        if (i_cmd.issue_term) begin
            r_feat_q <= r_feat[i_term[FW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_wr) begin
            r_act[act_wr_addr] <= sig_res;
        end
        if (i_cmd.issue_term) begin
            r_act_q <= r_act[act_rd_addr];
        end
    end

    // store walk pointers, kept modulo the store depth
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_row  <= '0;
            r_bptr <= BIAS_PTR;
        end
        if (i_cmd.hid_init) begin
            r_wptr <= HLW_PTR;
        end
        if (i_cmd.out_init) begin
            r_bptr <= OB_PTR;
        end
        if (i_cmd.issue_bias) begin
            r_bptr <= ptr_inc(r_bptr);
            if (i_cmd.input_layer) begin
                r_wptr <= r_row;
                r_row  <= (row_sum >= DEPTH_V) ? AW'(row_sum - DEPTH_V) : row_sum[AW-1:0];
            end
        end
        if (i_cmd.issue_term) begin
            r_wptr <= ptr_inc(r_wptr);
        end
    end

    // multiply-accumulate pipeline: read, product, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_bias <= 1'b0;
            r_s1_term <= 1'b0;
            r_s2_bias <= 1'b0;
            r_s2_term <= 1'b0;
        end else begin
            r_s1_bias <= i_cmd.issue_bias;
            r_s1_term <= i_cmd.issue_term;
            r_s2_bias <= r_s1_bias;
            r_s2_term <= r_s1_term;
        end
    end

    assign mac_a     = r_s1_in ? r_feat_q : {1'b0, r_act_q};
    assign prod_full = $signed({1'b0, mac_a}) * $signed(r_wq);
    assign acc_sum   = {{(PW-31){r_acc[31]}}, r_acc} + {r_prod[PW-1], r_prod};

    always_ff @(posedge i_clk) begin
        r_s1_in <= i_cmd.input_layer;
        if (r_s1_bias) begin
            r_prod <= {{(PW-32){r_wq[31]}}, r_wq};
        end else if (r_s1_term) begin
            // arithmetic shift gives the floored Q16.16 product
            r_prod <= prod_full[PW+15:16];
        end
        if (r_s2_bias) begin
            r_acc <= r_prod[31:0];
        end else if (r_s2_term) begin
            if (acc_sum > 35'sh0_7FFF_FFFF) begin
                r_acc <= 32'sh7FFF_FFFF;
            end else if (acc_sum < -35'sh0_8000_0000) begin
                r_acc <= -32'sh8000_0000;
            end else begin
                r_acc <= acc_sum[31:0];
            end
        end
    end

    mlp_sigmoid u_sigmoid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.sig_start),
        .i_acc    (r_acc),
        .o_done   (sig_done),
        .o_result (sig_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= 2'(i_neuron);
            r_out_value <= sig_res;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_sts.sig_done = sig_done;
    assign o_output_index = r_out_index;
    assign o_output_value = r_out_value;
    assign o_last_output  = r_out_last;

endmodule
`default_nettype wire

### hdl/mlp_ctrl.sv
`default_nettype none
module mlp_ctrl #(
    parameter int INPUT_COUNT  = 16,
    parameter int HIDDEN_COUNT = 16,
    parameter int LAYER_COUNT  = 2,
    parameter int OUTPUT_COUNT = 4,
    localparam int MXK = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT,
    localparam int KW  = $clog2((MXK > 2) ? MXK : 2),
    localparam int NOUT = (OUTPUT_COUNT < mlp_pkg::MAX_RESULTS) ? OUTPUT_COUNT
                                                                : mlp_pkg::MAX_RESULTS,
    localparam int MXN = (HIDDEN_COUNT > NOUT) ? HIDDEN_COUNT : NOUT,
    localparam int NW  = $clog2((MXN > 2) ? MXN : 2),
    localparam int FW  = $clog2(INPUT_COUNT)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_action,
    input  wire logic                i_last,
    input  wire logic                i_out_ready,
    input  wire mlp_pkg::t_dp_sts    i_sts,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output mlp_pkg::t_dp_cmd         o_cmd,
    output logic [KW-1:0]            o_term,
    output logic [NW-1:0]            o_neuron,
    output logic [FW-1:0]            o_feat_idx,
    output logic                     o_bank
);
    localparam int CW = $clog2(INPUT_COUNT + 1);
    localparam int TW = $clog2(MXK + 1);
    localparam int LW = $clog2(LAYER_COUNT + 1);
    localparam logic [LW-1:0] OUT_LAYER = LW'(LAYER_COUNT);
    localparam logic [CW-1:0] IN_CNT    = CW'(INPUT_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIAS  = 3'd1;
    localparam logic [2:0] S_TERM  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SIG   = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_STORE = 3'd6;

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_run, n_run;
    logic [LW-1:0]  r_layer, n_layer;
    logic [NW-1:0]  r_neuron, n_neuron;
    logic [KW-1:0]  r_term, n_term;
    logic           r_drain, n_drain;
    logic           r_out_valid, n_out_valid;

    logic           in_acc;
    logic           is_out;
    logic           out_free;
    logic           advance;
    logic [TW-1:0]  terms;
    logic [CW-1:0]  cnt_inc;
    logic [NW-1:0]  last_j;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign is_out   = (r_layer == OUT_LAYER);
    assign out_free = !r_out_valid || i_out_ready;
    assign terms    = (r_layer == '0) ? TW'(r_run) : TW'(HIDDEN_COUNT);
    assign cnt_inc  = (r_count < IN_CNT) ? r_count + CW'(1) : r_count;
    assign last_j   = is_out ? NW'(NOUT - 1) : NW'(HIDDEN_COUNT - 1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_run       = r_run;
        n_layer     = r_layer;
        n_neuron    = r_neuron;
        n_term      = r_term;
        n_drain     = r_drain;
        o_cmd       = '0;
        advance     = 1'b0;
        o_cmd.input_layer = (r_layer == '0);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action == mlp_pkg::ACTION_WEIGHT) begin
                        o_cmd.store_wr = 1'b1;
                    end else begin
                        o_cmd.feat_wr = (r_count < IN_CNT);
                        n_count       = cnt_inc;
                        if (i_last) begin
                            o_cmd.run_init = 1'b1;
                            n_run    = cnt_inc;
                            n_count  = '0;
                            n_layer  = '0;
                            n_neuron = '0;
                            n_state  = S_BIAS;
                        end
                    end
                end
            end
            S_BIAS: begin
                o_cmd.issue_bias = 1'b1;
                n_term  = '0;
                n_drain = 1'b0;
                n_state = (terms == '0) ? S_DRAIN : S_TERM;
            end
            S_TERM: begin
                o_cmd.issue_term = 1'b1;
                if (TW'(r_term) + TW'(1) == terms) begin
                    n_state = S_DRAIN;
                end else begin
                    n_term = r_term + KW'(1);
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_SIG;
                end
            end
            S_SIG: begin
                o_cmd.sig_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.sig_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (!is_out) begin
                    o_cmd.act_wr = 1'b1;
                    advance = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_neuron == last_j);
                    advance = 1'b1;
                end
                if (advance) begin
                    if (r_neuron == last_j) begin
                        if (is_out) begin
                            n_state = S_IDLE;
                        end else begin
                            n_layer  = r_layer + LW'(1);
                            n_neuron = '0;
                            o_cmd.hid_init = (r_layer == '0);
                            o_cmd.out_init = (r_layer + LW'(1) == OUT_LAYER);
                            n_state  = S_BIAS;
                        end
                    end else begin
                        n_neuron = r_neuron + NW'(1);
                        n_state  = S_BIAS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_run       <= '0;
            r_layer     <= '0;
            r_neuron    <= '0;
            r_term      <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_run       <= n_run;
            r_layer     <= n_layer;
            r_neuron    <= n_neuron;
            r_term      <= n_term;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_term      = r_term;
    assign o_neuron    = r_neuron;
    assign o_feat_idx  = r_count[FW-1:0];
    assign o_bank      = r_layer[0];

endmodule
`default_nettype wire

### hdl/mlp_forward_inference.sv
// fixed-point multilayer perceptron, forward pass only
// input channel (i_in_valid / o_in_ready): each transaction either writes one
//   Q16.16 weight or bias into the store (action weight) or delivers one Q1.16
//   feature (action feature); a feature with i_last set starts a run
// output channel (o_out_valid / i_out_ready): one transaction per output
//   neuron (at most four), Q0.16 sigmoid value, o_last_output on the final one
// while idle, weight writes and non-final features are accepted back to back;
//   a run occupies the single multiply-accumulate unit and the sigmoid unit
//   one neuron at a time, and a saturating sigmoid ends at its prep step;
//   the input is held off meanwhile
// reset: synchronous, clears the feature count and all control state; store
//   contents are undefined until written and must be loaded before a run
// a stalled receiver holds the result register; computation of the next
//   output waits for it, and new transactions are taken once the run is done
`default_nettype none
module mlp_forward_inference #(
    parameter int INPUT_COUNT  = 16,
    parameter int HIDDEN_COUNT = 16,
    parameter int LAYER_COUNT  = 2,
    parameter int OUTPUT_COUNT = 4,
    parameter int STORE_DEPTH  = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_action,
    input  wire logic [9:0]                          i_weight_addr,
    input  wire logic signed [31:0]                  i_weight_value,
    input  wire logic [mlp_pkg::FEAT_W-1:0]          i_feature_value,
    input  wire logic                                i_last,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [1:0]                               o_output_index,
    output logic [mlp_pkg::ACT_W-1:0]                o_output_value,
    output logic                                     o_last_output
);
    localparam int MXK = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
    localparam int KW  = $clog2((MXK > 2) ? MXK : 2);
    localparam int NOUT = (OUTPUT_COUNT < mlp_pkg::MAX_RESULTS) ? OUTPUT_COUNT
                                                                : mlp_pkg::MAX_RESULTS;
    localparam int MXN = (HIDDEN_COUNT > NOUT) ? HIDDEN_COUNT : NOUT;
    localparam int NW  = $clog2((MXN > 2) ? MXN : 2);
    localparam int FW  = $clog2(INPUT_COUNT);

    // controller to datapath commands and status
    mlp_pkg::t_dp_cmd  cmd;
    mlp_pkg::t_dp_sts  sts;
    logic [KW-1:0]     term;
    logic [NW-1:0]     neuron;
    logic [FW-1:0]     feat_idx;
    logic              bank;

    // sequencing: layer, neuron and term counters, handshakes
    mlp_ctrl #(
        .INPUT_COUNT  (INPUT_COUNT),
        .HIDDEN_COUNT (HIDDEN_COUNT),
        .LAYER_COUNT  (LAYER_COUNT),
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_last      (i_last),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .o_term      (term),
        .o_neuron    (neuron),
        .o_feat_idx  (feat_idx),
        .o_bank      (bank)
    );

    // storage, MAC pipeline, sigmoid and result register
    mlp_datapath #(
        .INPUT_COUNT  (INPUT_COUNT),
        .HIDDEN_COUNT (HIDDEN_COUNT),
        .LAYER_COUNT  (LAYER_COUNT),
        .OUTPUT_COUNT (OUTPUT_COUNT),
        .STORE_DEPTH  (STORE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_term          (term),
        .i_neuron        (neuron),
        .i_feat_idx      (feat_idx),
        .i_bank          (bank),
        .i_weight_addr   (i_weight_addr),
        .i_weight_value  (i_weight_value),
        .i_feature_value (i_feature_value),
        .o_sts           (sts),
        .o_output_index  (o_output_index),
        .o_output_value  (o_output_value),
        .o_last_output   (o_last_output)
    );

endmodule
`default_nettype wire

### sim/tb_mlp_forward_inference.sv
`default_nettype none
module tb_mlp_forward_inference;

    // network sizes and store layout, matching the default build of the block
    localparam int N_IN      = 16;
    localparam int N_HID     = 16;
    localparam int N_LAYER   = 2;
    localparam int N_OUT     = 4;
    localparam int DEPTH     = 1024;
    localparam int BIAS_BASE = N_IN * N_HID;
    localparam int HLW_BASE  = BIAS_BASE + N_LAYER * N_HID;
    localparam int OW_BASE   = HLW_BASE + (N_LAYER - 1) * N_HID * N_HID;
    localparam int OB_BASE   = OW_BASE + N_OUT * N_HID;
    localparam int USED      = OB_BASE + N_OUT;

    localparam int RAND_ITEMS  = 170;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 4000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_action = mlp_pkg::ACTION_WEIGHT;
    logic [9:0]                  i_weight_addr = '0;
    logic signed [31:0]          i_weight_value = '0;
    logic [mlp_pkg::FEAT_W-1:0]  i_feature_value = '0;
    logic                        i_last = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [1:0]                  o_output_index;
    logic [mlp_pkg::ACT_W-1:0]   o_output_value;
    logic                        o_last_output;

    always #4 i_clk = ~i_clk;

    mlp_forward_inference u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_weight_addr   (i_weight_addr),
        .i_weight_value  (i_weight_value),
        .i_feature_value (i_feature_value),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_output_index  (o_output_index),
        .o_output_value  (o_output_value),
        .o_last_output   (o_last_output)
    );

    // one expected output transaction
    typedef struct packed {
        logic [1:0]  idx;
        logic [15:0] val;
        logic        lst;
    } t_neuron_out;

    // shadow copy of the network state
    logic [31:0] weights [DEPTH];
    logic [16:0] features [N_IN];
    logic [15:0] acts [N_LAYER*N_HID];
    int          feat_cnt = 0;

    t_neuron_out pending_outs[$];
    int          mismatches = 0;
    int          n_results = 0;
    int          n_runs = 0;
    int          n_items = 0;
    bit          stim_done = 1'b0;
    bit          quiet_out = 1'b0;   // no idling on the receiver
    bit          quiet_in = 1'b0;    // no idling on the sender

    // typed expectation carried with the current transaction
    bit               cur_typed = 1'b0;
    logic [3:0][15:0] cur_typed_vals;

    function automatic longint fetch_weight(int a);
        return longint'($signed(weights[a % DEPTH]));
    endfunction

    function automatic longint mac_sat(longint acc, longint a, longint w);
        longint s;
        s = acc + ((a * w) >>> 16);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    function automatic logic [15:0] sigmoid_q16(longint r);
        longint u;
        if (r > 524288) return 16'd65535;
        if (r < -524288) return 16'd0;
        if (r > 393216) return 16'((64'sd654049280 + r) / 10000);
        if (r > 212992) return 16'((64'sd638976000 + 28 * r) / 10000);
        if (r >= 0) return 16'(32768 + (r * 22200001) / 157130000);
        u = 524288 + r;
        return 16'((u * u * 71) / 655360000);
    endfunction

    // full forward pass on the shadow state, queues one result per output neuron
    task automatic run_network(int count, bit typed, logic [3:0][15:0] typed_vals);
        longint acc;
        t_neuron_out r;
        for (int j = 0; j < N_HID; j++) begin
            acc = fetch_weight(BIAS_BASE + j);
            for (int k = 0; k < N_IN && k < count; k++)
                acc = mac_sat(acc, features[k], fetch_weight(j * N_IN + k));
            acts[j] = sigmoid_q16(acc);
        end
        for (int p = 1; p < N_LAYER; p++) begin
            for (int j = 0; j < N_HID; j++) begin
                acc = fetch_weight(BIAS_BASE + p * N_HID + j);
                for (int k = 0; k < N_HID; k++)
                    acc = mac_sat(acc, acts[(p-1)*N_HID + k],
                        fetch_weight(HLW_BASE + ((p-1)*N_HID + j)*N_HID + k));
                acts[p*N_HID + j] = sigmoid_q16(acc);
            end
        end
        for (int j = 0; j < N_OUT && j < mlp_pkg::MAX_RESULTS; j++) begin
            acc = fetch_weight(OB_BASE + j);
            for (int k = 0; k < N_HID; k++)
                acc = mac_sat(acc, acts[(N_LAYER-1)*N_HID + k],
                    fetch_weight(OW_BASE + j*N_HID + k));
            r.idx = 2'(j);
            r.val = typed ? typed_vals[j] : sigmoid_q16(acc);
            r.lst = (j == N_OUT - 1 || j == mlp_pkg::MAX_RESULTS - 1);
            pending_outs.push_back(r);
        end
        n_runs++;
    endtask

    // input side monitor: updates the shadow state on every accepted transaction
    always @(posedge i_clk) begin
        logic [16:0] f;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            n_items++;
            if (i_action == mlp_pkg::ACTION_WEIGHT) begin
                weights[i_weight_addr] = i_weight_value;
            end else begin
                f = (i_feature_value > mlp_pkg::FEAT_MAX) ? mlp_pkg::FEAT_MAX
                                                          : i_feature_value;
                if (feat_cnt < N_IN) begin
                    features[feat_cnt] = f;
                    feat_cnt++;
                end
                if (i_last) begin
                    run_network(feat_cnt, cur_typed, cur_typed_vals);
                    feat_cnt = 0;
                end
            end
        end
    end

    // output side checker
    always @(posedge i_clk) begin
        t_neuron_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_outs.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: idx %0d val %0d last %0b",
                             o_output_index, o_output_value, o_last_output);
                mismatches++;
            end else begin
                e = pending_outs.pop_front();
                if (e.idx !== o_output_index || e.val !== o_output_value
                        || e.lst !== o_last_output) begin
                    if (mismatches < 10)
                        $display("mismatch: exp idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
                                 e.idx, e.val, e.lst, o_output_index, o_output_value,
                                 o_last_output);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        int idle;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: random gaps, plus one long hold-off so the block backs up
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && n_runs >= 8) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = quiet_out ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // drive one input transaction, return once accepted (called at a falling edge)
    task automatic send_item(logic act, logic [9:0] addr, logic [31:0] wv,
                             logic [16:0] fv, logic lst);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_weight_addr   <= addr;
        i_weight_value  <= wv;
        i_feature_value <= fv;
        i_last          <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_weight();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
    endfunction

    function automatic logic [16:0] rand_feature();
        if ($urandom_range(0, 9) == 0) return 17'($urandom_range(65537, 17'h1FFFF));
        return 17'($urandom_range(0, 65536));
    endfunction

    // directed rows; typed rows carry the four output values read off the layout
    typedef struct {
        logic             act;
        logic [9:0]       addr;
        logic [31:0]      wv;
        logic [16:0]      fv;
        logic             lst;
        bit               typed;
        logic [3:0][15:0] vals;
    } t_stim_row;

    localparam logic [3:0][15:0] NO_VALS = '0;
    localparam logic A_W = mlp_pkg::ACTION_WEIGHT;
    localparam logic A_F = mlp_pkg::ACTION_FEATURE;

    t_stim_row stim_table [] = '{
        // all weights zero: every neuron sits at sigmoid(0)
        '{A_F, 10'd0,    32'h0,        17'd0,      1'b1, 1'b1,
          {16'd32768, 16'd32768, 16'd32768, 16'd32768}},
        // output biases at the extremes and in the upper knee
        '{A_W, 10'd608,  32'h7FFFFFFF, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd609,  32'h80000000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd611,  32'h00068000, 17'd0,      1'b0, 1'b0, NO_VALS},
        // feature above one, saturated; input weights still zero
        '{A_F, 10'd0,    32'h0,        17'h1FFFF,  1'b1, 1'b1,
          {16'd65447, 16'd32768, 16'd0, 16'd65535}},
        // linear, lower edge, quadratic and middle knee segments
        '{A_W, 10'd608,  32'h00010000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd609,  32'hFFF80000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd610,  32'hFFFC0000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd611,  32'h00040000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_F, 10'd0,    32'h0,        17'd65536,  1'b1, 1'b1,
          {16'd64631, 16'd7444, 16'd0, 16'd42027}},
        // nonzero input weight, hidden bias and output weight, and an unused entry; last set on a write is ignored
        '{A_W, 10'd0,    32'h00010000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd256,  32'hFFFF8000, 17'd0,      1'b1, 1'b0, NO_VALS},
        '{A_W, 10'd544,  32'h00028000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_W, 10'd1023, 32'h7FFFFFFF, 17'd0,      1'b0, 1'b0, NO_VALS},
        // short vector of two features
        '{A_F, 10'd0,    32'h0,        17'd40000,  1'b0, 1'b0, NO_VALS},
        '{A_F, 10'd0,    32'h0,        17'd65536,  1'b1, 1'b0, NO_VALS},
        // most negative input weight
        '{A_W, 10'd1,    32'h80000000, 17'd0,      1'b0, 1'b0, NO_VALS},
        '{A_F, 10'd0,    32'h0,        17'd65536,  1'b0, 1'b0, NO_VALS},
        '{A_F, 10'd0,    32'h0,        17'd65536,  1'b1, 1'b0, NO_VALS}
    };

    initial begin
        int rand_count;
        int vec_len;
        int wait_cycles;
        rand_count = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // load the whole used part of the store so no unwritten entry is read
        quiet_in = 1'b1;
        for (int a = 0; a < USED; a++)
            send_item(mlp_pkg::ACTION_WEIGHT, 10'(a), 32'h0, 17'd0, 1'b0);
        quiet_in = 1'b0;

        foreach (stim_table[i]) begin
            cur_typed      = stim_table[i].typed;
            cur_typed_vals = stim_table[i].vals;
            send_item(stim_table[i].act, stim_table[i].addr, stim_table[i].wv,
                      stim_table[i].fv, stim_table[i].lst);
        end
        cur_typed = 1'b0;

        // random part: mostly whole vectors with writes mixed in
        while (rand_count < RAND_ITEMS) begin
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       vec_len = $urandom_range(1, N_IN - 1);
                1:       vec_len = $urandom_range(N_IN + 1, N_IN + 4);
                default: vec_len = N_IN;
            endcase
            for (int k = 0; k < vec_len; k++) begin
                while ($urandom_range(0, 6) == 0) begin
                    send_item(mlp_pkg::ACTION_WEIGHT,
                              ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                                          : 10'($urandom_range(0, USED - 1)),
                              rand_weight(), 17'($urandom), 1'($urandom));
                    rand_count++;
                end
                send_item(mlp_pkg::ACTION_FEATURE, 10'($urandom), 32'($urandom),
                          rand_feature(), k == vec_len - 1);
                rand_count++;
            end
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;

        wait_cycles = 0;
        while (pending_outs.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2000) @(posedge i_clk);

        $display("%0d input transactions, %0d network runs, %0d results checked",
                 n_items, n_runs, n_results);
        if (mismatches == 0 && pending_outs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_outs.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hdl/mlp_pkg.sv
hdl/mlp_sigmoid.sv
hdl/mlp_datapath.sv
hdl/mlp_ctrl.sv
hdl/mlp_forward_inference.sv
sim/tb_mlp_forward_inference.sv
